### rtl/mp2_pkg.sv
// shared types and constants for the mp2rage contrast and t1 lookup block
// no dependencies; used by mp2_ctrl, mp2_datapath and the top-level module
package mp2_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int CNT_W       = LEN_W;

    localparam int CFG_W       = 13;
    localparam int IDX_W       = 12;
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int NUM_W       = PROD_W + 1;
    localparam int ENERGY_W    = PROD_W + 1;
    localparam int QUO_W       = 15;
    localparam int REM_W       = NUM_W + 16;
    localparam int DIST_W      = 17;
    localparam int WORD_W      = 32;

    localparam int MUL_STEPS   = 6;
    localparam int DIV_STEPS   = QUO_W;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_SIGN,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MUL_AR_BR,
        MUL_AI_BI,
        MUL_AR_AR,
        MUL_AI_AI,
        MUL_BR_BR,
        MUL_BI_BI
    } mul_sel_t;

    typedef struct packed {
        logic              load_we;
        logic              capture;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic              div_init;
        logic              div_step;
        logic              sign_set;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] scan_len;
        logic             out_busy;
    } stat_t;

endpackage

### rtl/mp2_ctrl.sv
// controller state machine: sequences multiply, divide and table scan
// depends on mp2_pkg
module mp2_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           kind,
    output logic           in_ready,
    input  mp2_pkg::stat_t stat,
    output mp2_pkg::cmd_t  cmd
);

    mp2_pkg::state_t               state_reg, state_next;
    logic [mp2_pkg::CNT_W-1:0]     cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mp2_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.mul_sel = mp2_pkg::mul_sel_t'(cnt_reg[2:0]);
        cmd.rd_addr = cnt_reg[mp2_pkg::ADDR_W-1:0];
        unique case (state_reg)
            mp2_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind == mp2_pkg::KIND_LOAD)
                    begin
                        cmd.load_we = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        cnt_next    = '0;
                        state_next  = mp2_pkg::ST_MUL;
                    end
                end
            end
            mp2_pkg::ST_MUL:
            begin
                // the final count issues no multiply and lets the last product reach the accumulators
                cmd.mul_en = (cnt_reg < mp2_pkg::CNT_W'(mp2_pkg::MUL_STEPS));
                if (cnt_reg == mp2_pkg::CNT_W'(mp2_pkg::MUL_STEPS))
                begin
                    cnt_next   = '0;
                    state_next = mp2_pkg::ST_PREP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            mp2_pkg::ST_PREP:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = mp2_pkg::ST_DIV;
            end
            mp2_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == mp2_pkg::CNT_W'(mp2_pkg::DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = mp2_pkg::ST_SIGN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            mp2_pkg::ST_SIGN:
            begin
                cmd.sign_set = 1'b1;
                cnt_next     = '0;
                state_next   = mp2_pkg::ST_SCAN;
            end
            mp2_pkg::ST_SCAN:
            begin
                // last cycle issues no read, only compares the final entry
                cmd.rd_en = (cnt_reg < mp2_pkg::CNT_W'(stat.scan_len));
                if (cnt_reg == mp2_pkg::CNT_W'(stat.scan_len))
                begin
                    cnt_next   = '0;
                    state_next = mp2_pkg::ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            mp2_pkg::ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mp2_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mp2_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/mp2_datapath.sv
// datapath: shared multiplier, restoring divider, table memory, nearest search
// and output register; depends on mp2_pkg
module mp2_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mp2_pkg::cmd_t          cmd,
    output mp2_pkg::stat_t         stat,
    input  logic                   cfg_wr_en,
    input  logic [12:0]            cfg_wr_data,
    input  logic [11:0]            entry_index,
    input  logic signed [15:0]     entry_contrast,
    input  logic [15:0]            entry_r1,
    input  logic signed [15:0]     first_real,
    input  logic signed [15:0]     first_imag,
    input  logic signed [15:0]     second_real,
    input  logic signed [15:0]     second_imag,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [15:0]     contrast,
    output logic [11:0]            best_entry,
    output logic [15:0]            r1_value,
    output logic                   zero_energy,
    output logic                   table_empty
);

    // configuration
    logic [mp2_pkg::CFG_W-1:0] entries_reg;
    logic [mp2_pkg::LEN_W-1:0] scan_len;

    // sample capture and products
    logic signed [15:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [15:0] op_a, op_b;
    logic signed [mp2_pkg::PROD_W-1:0]   prod_reg;
    mp2_pkg::mul_sel_t                   prod_sel_reg;
    logic                                prod_vld_reg;
    logic signed [mp2_pkg::NUM_W-1:0]    num_reg;
    logic [mp2_pkg::ENERGY_W-1:0]        energy_reg;

    // divider
    logic [mp2_pkg::NUM_W-1:0]  mag;
    logic [mp2_pkg::REM_W-1:0]  rem_reg, dsh_reg;
    logic [mp2_pkg::QUO_W-1:0]  quo_reg;
    logic                       neg_reg;
    logic                       rem_ge;
    logic signed [15:0]         c_reg;
    logic                       zero_reg;

    // table and search
    logic [mp2_pkg::WORD_W-1:0] mem [mp2_pkg::TABLE_DEPTH];
    logic [mp2_pkg::WORD_W-1:0] mem_q_reg;
    logic                       rd_vld_reg;
    logic [mp2_pkg::ADDR_W-1:0] rd_idx_reg;
    logic signed [15:0]         tbl_c;
    logic signed [mp2_pkg::DIST_W-1:0] diff;
    logic [mp2_pkg::DIST_W-1:0] dist_abs;
    logic                       take;
    logic [mp2_pkg::DIST_W-1:0] best_dist_reg;
    logic [mp2_pkg::ADDR_W-1:0] best_idx_reg;
    logic [15:0]                best_r1_reg;
    logic                       load_ok;

    // output register
    logic                       out_valid_reg;
    logic signed [15:0]         contrast_reg;
    logic [11:0]                best_entry_reg;
    logic [15:0]                r1_value_reg;
    logic                       zero_energy_reg;
    logic                       table_empty_reg;

    assign scan_len = (32'(entries_reg) > mp2_pkg::TABLE_DEPTH)
                    ? mp2_pkg::LEN_W'(mp2_pkg::TABLE_DEPTH)
                    : mp2_pkg::LEN_W'(entries_reg);

    assign stat.scan_len = scan_len;
    assign stat.out_busy = out_valid_reg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            mp2_pkg::MUL_AR_BR: begin op_a = ar_reg; op_b = br_reg; end
            mp2_pkg::MUL_AI_BI: begin op_a = ai_reg; op_b = bi_reg; end
            mp2_pkg::MUL_AR_AR: begin op_a = ar_reg; op_b = ar_reg; end
            mp2_pkg::MUL_AI_AI: begin op_a = ai_reg; op_b = ai_reg; end
            mp2_pkg::MUL_BR_BR: begin op_a = br_reg; op_b = br_reg; end
            mp2_pkg::MUL_BI_BI: begin op_a = bi_reg; op_b = bi_reg; end
            default:            begin op_a = '0;     op_b = '0;     end
        endcase
    end

    assign mag    = num_reg[mp2_pkg::NUM_W-1] ? mp2_pkg::NUM_W'(-num_reg)
                                              : mp2_pkg::NUM_W'(num_reg);
    assign rem_ge = (rem_reg >= dsh_reg);

    assign tbl_c    = mem_q_reg[31:16];
    assign diff     = mp2_pkg::DIST_W'(tbl_c) - mp2_pkg::DIST_W'(c_reg);
    assign dist_abs = diff[mp2_pkg::DIST_W-1] ? mp2_pkg::DIST_W'(-diff)
                                              : mp2_pkg::DIST_W'(diff);
    assign take     = rd_vld_reg && ((rd_idx_reg == '0) || (dist_abs < best_dist_reg));

    assign load_ok = (32'(entry_index) < mp2_pkg::TABLE_DEPTH);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg   <= '0;
            prod_vld_reg  <= 1'b0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                entries_reg <= cfg_wr_data;
            end
            prod_vld_reg <= cmd.mul_en;
            rd_vld_reg   <= cmd.rd_en;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ar_reg     <= first_real;
            ai_reg     <= first_imag;
            br_reg     <= second_real;
            bi_reg     <= second_imag;
            num_reg    <= '0;
            energy_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            if (prod_sel_reg == mp2_pkg::MUL_AR_BR || prod_sel_reg == mp2_pkg::MUL_AI_BI)
            begin
                num_reg <= num_reg + mp2_pkg::NUM_W'(prod_reg);
            end
            else
            begin
                energy_reg <= energy_reg + mp2_pkg::ENERGY_W'(unsigned'(prod_reg));
            end
        end
        prod_reg     <= op_a * op_b;
        prod_sel_reg <= cmd.mul_sel;

        // divisor is 2 * energy; first compare is at quotient bit 14
        if (cmd.div_init)
        begin
            rem_reg  <= mp2_pkg::REM_W'({mag, 16'b0}) + mp2_pkg::REM_W'(energy_reg);
            dsh_reg  <= mp2_pkg::REM_W'({energy_reg, 15'b0});
            quo_reg  <= '0;
            neg_reg  <= num_reg[mp2_pkg::NUM_W-1];
            zero_reg <= (energy_reg == '0);
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[mp2_pkg::QUO_W-2:0], rem_ge};
        end

        if (cmd.sign_set)
        begin
            if (zero_reg)
            begin
                c_reg <= '0;
            end
            else if (neg_reg)
            begin
                c_reg <= -signed'({1'b0, quo_reg});
            end
            else
            begin
                c_reg <= signed'({1'b0, quo_reg});
            end
        end
    end

    // table memory: {contrast, r1} per entry
    always_ff @(posedge clk)
    begin
        if (cmd.load_we && load_ok)
        begin
            mem[mp2_pkg::ADDR_W'(entry_index)] <= {entry_contrast, entry_r1};
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[cmd.rd_addr];
        end
    end

    // nearest search and result register
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cmd.rd_addr;
        if (take)
        begin
            best_dist_reg <= dist_abs;
            best_idx_reg  <= rd_idx_reg;
            best_r1_reg   <= mem_q_reg[15:0];
        end
        if (cmd.out_load)
        begin
            contrast_reg    <= c_reg;
            zero_energy_reg <= zero_reg;
            table_empty_reg <= (scan_len == '0);
            best_entry_reg  <= (scan_len == '0) ? '0 : 12'(best_idx_reg);
            r1_value_reg    <= (scan_len == '0) ? '0 : best_r1_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign contrast    = contrast_reg;
    assign best_entry  = best_entry_reg;
    assign r1_value    = r1_value_reg;
    assign zero_energy = zero_energy_reg;
    assign table_empty = table_empty_reg;

endmodule

### rtl/mp2rage_contrast_t1_lookup.sv
// a load beat is written into the table in the cycle it is taken; a query
// runs multiply, divide and a scan of entries_in_use entries (saturated at the
// table depth) before its result is registered; one query at a time, with the
// table scan reading one entry per cycle; loads are taken one per cycle when idle
// reset: rst_n async active low clears the state machine, valid flags and
// entries_in_use; the table holds no reset and must be loaded before use
module mp2rage_contrast_t1_lookup (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [12:0]        cfg_wr_data,
    // input beats
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [11:0]        entry_index,
    input  logic signed [15:0] entry_contrast,
    input  logic [15:0]        entry_r1,
    input  logic signed [15:0] first_real,
    input  logic signed [15:0] first_imag,
    input  logic signed [15:0] second_real,
    input  logic signed [15:0] second_imag,
    // result beats
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] contrast,
    output logic [11:0]        best_entry,
    output logic [15:0]        r1_value,
    output logic               zero_energy,
    output logic               table_empty
);

    // command and status between controller and datapath
    mp2_pkg::cmd_t  cmd;
    mp2_pkg::stat_t stat;

    // controller: idle/accept, multiply, divide, scan, hand off to result reg
    mp2_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: one 16x16 multiplier shared over six products, a radix-2
    // restoring divider giving the rounded contrast, the entry memory read
    // once per cycle during the scan, and the result register that lets a
    // new beat in while a finished result waits
    mp2_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .entry_index    (entry_index),
        .entry_contrast (entry_contrast),
        .entry_r1       (entry_r1),
        .first_real     (first_real),
        .first_imag     (first_imag),
        .second_real    (second_real),
        .second_imag    (second_imag),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .contrast       (contrast),
        .best_entry     (best_entry),
        .r1_value       (r1_value),
        .zero_energy    (zero_energy),
        .table_empty    (table_empty)
    );

endmodule

### rtl/mp2_checker.sv
// port-level checks for the lookup block's result channel
// attached to mp2rage_contrast_t1_lookup by the bind at the end of the file
module mp2_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] contrast,
    input logic [11:0]        best_entry,
    input logic [15:0]        r1_value,
    input logic               zero_energy,
    input logic               table_empty
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(contrast)
            && $stable(best_entry) && $stable(r1_value))
        else $error("result beat changed while stalled");

    a_contrast_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (contrast >= -16'sd16384) && (contrast <= 16'sd16384))
        else $error("contrast out of range");

    a_zero_energy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_energy |-> contrast == 16'sd0)
        else $error("zero energy with nonzero contrast");

    a_empty_table: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_empty |-> best_entry == 12'd0 && r1_value == 16'd0)
        else $error("empty table with nonzero entry or r1");

endmodule

bind mp2rage_contrast_t1_lookup mp2_checker u_mp2_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .contrast    (contrast),
    .best_entry  (best_entry),
    .r1_value    (r1_value),
    .zero_energy (zero_energy),
    .table_empty (table_empty)
);
